/* design/tbgtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbgtd_pkg: shared types and constants
// Register indexes, controller commands, status and fixed widths.
// ----------------------------------------------------------------------------
package tbgtd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 40;
  localparam int PWR_W      = 48;
  localparam int CS_W       = 36;
  localparam int COEF_W     = 18;
  localparam int MODE_W     = 2;
  localparam int LEN_W      = 13;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [MODE_W-1:0] MODE_RST      = 2'd1;
  localparam logic [LEN_W-1:0]  BLOCK_LEN_RST = 13'd4096;
  localparam logic [CS_W-1:0]   BIN_CS_RST    = 36'h4_0000_0000;
  localparam logic [GAIN_W-1:0] THRESH_RST    = 16'd256;
  localparam logic [GAIN_W-1:0] ALPHA_RST     = 16'd6554;
  localparam logic [PWR_W-1:0]  PWR_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_BLOCK_LEN  = 3'd1,
    REG_CENTRAL_CS = 3'd2,
    REG_RIGHT_CS   = 3'd3,
    REG_LEFT_CS    = 3'd4,
    REG_THRESH     = 3'd5,
    REG_ALPHA      = 3'd6,
    REG_FLOOR      = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,
    OP_DROP = 4'd2,
    OP_REC  = 4'd3,
    OP_CNT  = 4'd4,
    OP_MUL  = 4'd5,
    OP_AB   = 4'd6,
    OP_SQA  = 4'd7,
    OP_SQB  = 4'd8,
    OP_AVG1 = 4'd9,
    OP_AVG2 = 4'd10,
    OP_DEC1 = 4'd11,
    OP_DEC2 = 4'd12,
    OP_OUT  = 4'd13
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] idx;   // recursion index: bin*2 + part
    logic [1:0] sub;   // end-of-block product number
    logic [1:0] bin;   // 0 central, 1 right, 2 left
  } cmd_t;

  typedef struct packed {
    logic mode_en;
    logic avg_en;
    logic last;        // current sample closes the block
    logic out_free;
  } sts_t;

endpackage

/* design/tbgtd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbgtd_ctrl: sequencing state machine
// Steps the datapath through six recursions per sample and the end-of-block
// power, averaging and decision sequence.
// ----------------------------------------------------------------------------
module tbgtd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tbgtd_pkg::sts_t sts_i,
  output tbgtd_pkg::cmd_t cmd_o
);
  import tbgtd_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_REC  = 12'b0000_0000_0010,
    ST_CNT  = 12'b0000_0000_0100,
    ST_MUL  = 12'b0000_0000_1000,
    ST_AB   = 12'b0000_0001_0000,
    ST_SQA  = 12'b0000_0010_0000,
    ST_SQB  = 12'b0000_0100_0000,
    ST_AVG1 = 12'b0000_1000_0000,
    ST_AVG2 = 12'b0001_0000_0000,
    ST_DEC1 = 12'b0010_0000_0000,
    ST_DEC2 = 12'b0100_0000_0000,
    ST_OUT  = 12'b1000_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic [1:0] sub_q, sub_d;
  logic [1:0] bin_q, bin_d;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sub_d      = sub_q;
    bin_d      = bin_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, idx: idx_q, sub: sub_q, bin: bin_q};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.mode_en) begin
            cmd_o.op = OP_LOAD;
            idx_d    = 3'd0;
            state_d  = ST_REC;
          end else begin
            cmd_o.op = OP_DROP;
          end
        end
      end
      ST_REC: begin
        cmd_o.op = OP_REC;
        if (idx_q == 3'd5) begin
          state_d = ST_CNT;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      ST_CNT: begin
        cmd_o.op = OP_CNT;
        bin_d    = 2'd0;
        sub_d    = 2'd0;
        state_d  = sts_i.last ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        sub_d    = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          state_d = ST_AB;
        end
      end
      ST_AB: begin
        cmd_o.op = OP_AB;
        state_d  = ST_SQA;
      end
      ST_SQA: begin
        cmd_o.op = OP_SQA;
        state_d  = ST_SQB;
      end
      ST_SQB: begin
        cmd_o.op = OP_SQB;
        if (sts_i.avg_en) begin
          state_d = ST_AVG1;
        end else if (bin_q == 2'd2) begin
          state_d = ST_DEC1;
        end else begin
          bin_d   = bin_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_AVG1: begin
        cmd_o.op = OP_AVG1;
        state_d  = ST_AVG2;
      end
      ST_AVG2: begin
        cmd_o.op = OP_AVG2;
        if (bin_q == 2'd2) begin
          state_d = ST_DEC1;
        end else begin
          bin_d   = bin_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_DEC1: begin
        cmd_o.op = OP_DEC1;
        state_d  = ST_DEC2;
      end
      ST_DEC2: begin
        cmd_o.op = OP_DEC2;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      sub_q   <= '0;
      bin_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      bin_q   <= bin_d;
    end
  end

endmodule

/* design/tbgtd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbgtd_dp: detector datapath
// Configuration registers, recursion state, shared coefficient multiplier,
// power, averager, decision and the output register.
// ----------------------------------------------------------------------------
module tbgtd_dp #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tbgtd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tbgtd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic signed [tbgtd_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [tbgtd_pkg::SAMPLE_W-1:0] sample_im_i,
  input  tbgtd_pkg::cmd_t                      cmd_i,
  output tbgtd_pkg::sts_t                      sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 detected_o,
  output logic                                 first_detect_o,
  output logic [tbgtd_pkg::PWR_W-1:0]          central_power_o,
  output logic [tbgtd_pkg::PWR_W-1:0]          left_power_o,
  output logic [tbgtd_pkg::PWR_W-1:0]          right_power_o
);
  import tbgtd_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK);
  localparam int SUM_W = ACC_W + 5;
  localparam logic signed [SUM_W-1:0] ACC_HI = (SUM_W'(1) <<< (ACC_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ACC_LO = -(SUM_W'(1) <<< (ACC_W - 1));
  localparam int T_W  = ACC_W + 2;
  localparam int AB_W = ACC_W + 4;

  // configuration
  logic [MODE_W-1:0] mode_q;
  logic [LEN_W-1:0]  block_len_q;
  logic [CS_W-1:0]   bin_cs_q [3];
  logic [GAIN_W-1:0] thresh_q;
  logic [GAIN_W-1:0] alpha_q;
  logic [PWR_W-1:0]  floor_q;

  // state
  logic signed [ACC_W-1:0] q1_q [6];
  logic signed [ACC_W-1:0] q2_q [6];
  logic [CNT_W-1:0]        cnt_q;
  logic [PWR_W-1:0]        avg_q [3];
  logic                    first_pend_q;

  // work registers
  logic signed [SAMPLE_W-1:0] re_q, im_q;
  logic signed [T_W-1:0]      t_q [4];
  logic [31:0]                ua_q, ub_q;
  logic                       big_q;
  logic [63:0]                a2_q;
  logic [PWR_W-1:0]           pw_q [3];
  logic [63:0]                acc_q;
  logic                       det1_q, det2_q;

  logic                       out_valid_q;
  logic                       det_oq, first_oq;
  logic [PWR_W-1:0]           cen_oq, left_oq, right_oq;

  // shared coefficient multiplier
  logic [1:0]                  mbin;
  logic [2:0]                  mrow;
  logic signed [COEF_W-1:0]    coef;
  logic signed [ACC_W-1:0]     opnd;
  logic signed [COEF_W+ACC_W-1:0] prod;

  always_comb begin
    if (cmd_i.op == OP_REC) begin
      mbin = cmd_i.idx[2:1];
      mrow = cmd_i.idx;
      coef = bin_cs_q[mbin][CS_W-1:COEF_W];
      opnd = q1_q[mrow];
    end else begin
      mbin = cmd_i.bin;
      mrow = {cmd_i.bin, cmd_i.sub[1]};
      coef = cmd_i.sub[0] ? bin_cs_q[mbin][COEF_W-1:0] : bin_cs_q[mbin][CS_W-1:COEF_W];
      opnd = q2_q[mrow];
    end
  end
  assign prod = coef * opnd;

  // recursion step with saturation
  logic signed [SUM_W-1:0] q0;
  logic signed [ACC_W-1:0] q0_sat;
  logic signed [SAMPLE_W-1:0] x_sel;
  assign x_sel = cmd_i.idx[0] ? im_q : re_q;
  assign q0 = SUM_W'(x_sel) + SUM_W'(prod >>> 15) - SUM_W'(q2_q[mrow]);
  always_comb begin
    if (q0 > ACC_HI)      q0_sat = ACC_W'(ACC_HI);
    else if (q0 < ACC_LO) q0_sat = ACC_W'(ACC_LO);
    else                  q0_sat = ACC_W'(q0);
  end

  // complex combine
  logic signed [AB_W-1:0] a_s, b_s;
  logic [AB_W-1:0]        ua, ub;
  assign a_s = AB_W'(q1_q[{cmd_i.bin, 1'b0}]) - AB_W'(t_q[0]) - AB_W'(t_q[3]);
  assign b_s = AB_W'(q1_q[{cmd_i.bin, 1'b1}]) - AB_W'(t_q[2]) + AB_W'(t_q[1]);
  assign ua  = a_s[AB_W-1] ? AB_W'(-a_s) : AB_W'(a_s);
  assign ub  = b_s[AB_W-1] ? AB_W'(-b_s) : AB_W'(b_s);

  // power
  logic [64:0]      psum;
  logic [PWR_W-1:0] praw, pwr;
  assign psum = 65'(a2_q) + 65'(64'(ub_q) * 64'(ub_q));
  assign praw = (big_q || psum[64]) ? PWR_MAX : psum[63:16];
  assign pwr  = (praw <= floor_q) ? PWR_W'(1) : praw;

  // averager
  logic [16:0]      na;
  logic [65:0]      asum;
  assign na   = 17'h1_0000 - 17'(alpha_q);
  assign asum = 66'(acc_q) + 66'(65'(na) * 65'(avg_q[cmd_i.bin]));

  // decision
  logic [63:0] lhs, rhs;
  assign lhs = 64'({pw_q[0], 8'b0});
  assign rhs = 64'((cmd_i.op == OP_DEC1) ? pw_q[2] : pw_q[1]) * 64'(thresh_q);

  // block length clamp
  logic [31:0] len_eff, cnt_next;
  always_comb begin
    if (block_len_q == '0)                len_eff = 32'd1;
    else if (32'(block_len_q) > MAX_BLOCK) len_eff = 32'(MAX_BLOCK);
    else                                   len_eff = 32'(block_len_q);
  end
  assign cnt_next = 32'(cnt_q) + 32'd1;

  logic det;
  assign det = det1_q && det2_q;

  assign sts_o.mode_en  = mode_q[0];
  assign sts_o.avg_en   = mode_q[1];
  assign sts_o.last     = cnt_next >= len_eff;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  logic clr_blk, clr_avg;
  assign clr_blk = (cmd_i.op == OP_DROP) || (cmd_i.op == OP_OUT) ||
                   (cfg_we_i && cfg_idx_i == REG_BLOCK_LEN);
  assign clr_avg = (cfg_we_i && (cfg_idx_i == REG_MODE || cfg_idx_i == REG_ALPHA)) ||
                   (cmd_i.op == OP_OUT && det && first_pend_q);

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_RST;
      block_len_q  <= BLOCK_LEN_RST;
      bin_cs_q[0]  <= BIN_CS_RST;
      bin_cs_q[1]  <= BIN_CS_RST;
      bin_cs_q[2]  <= BIN_CS_RST;
      thresh_q     <= THRESH_RST;
      alpha_q      <= ALPHA_RST;
      floor_q      <= '0;
      cnt_q        <= '0;
      first_pend_q <= 1'b1;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        q1_q[i] <= '0;
        q2_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        avg_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:       mode_q      <= cfg_wdata_i[MODE_W-1:0];
          REG_BLOCK_LEN:  block_len_q <= cfg_wdata_i[LEN_W-1:0];
          REG_CENTRAL_CS: bin_cs_q[0] <= cfg_wdata_i[CS_W-1:0];
          REG_RIGHT_CS:   bin_cs_q[1] <= cfg_wdata_i[CS_W-1:0];
          REG_LEFT_CS:    bin_cs_q[2] <= cfg_wdata_i[CS_W-1:0];
          REG_THRESH:     thresh_q    <= cfg_wdata_i[GAIN_W-1:0];
          REG_ALPHA:      alpha_q     <= cfg_wdata_i[GAIN_W-1:0];
          REG_FLOOR:      floor_q     <= cfg_wdata_i[PWR_W-1:0];
          default:        ;
        endcase
      end

      if (cmd_i.op == OP_REC) begin
        q2_q[mrow] <= q1_q[mrow];
        q1_q[mrow] <= q0_sat;
      end
      if (cmd_i.op == OP_CNT && !sts_o.last) begin
        cnt_q <= CNT_W'(cnt_next);
      end
      if (clr_blk) begin
        cnt_q <= '0;
        for (int i = 0; i < 6; i++) begin
          q1_q[i] <= '0;
          q2_q[i] <= '0;
        end
      end

      if (cmd_i.op == OP_AVG2) begin
        avg_q[cmd_i.bin] <= asum[63:16];
      end
      if (cmd_i.op == OP_OUT) begin
        first_pend_q <= !det;
      end
      if (clr_avg) begin
        for (int i = 0; i < 3; i++) begin
          avg_q[i] <= '0;
        end
      end

      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      re_q <= sample_re_i;
      im_q <= sample_im_i;
    end
    if (cmd_i.op == OP_MUL) begin
      t_q[cmd_i.sub] <= T_W'(prod >>> 16);
    end
    if (cmd_i.op == OP_AB) begin
      ua_q  <= ua[31:0];
      ub_q  <= ub[31:0];
      big_q <= (|ua[AB_W-1:32]) || (|ub[AB_W-1:32]);
    end
    if (cmd_i.op == OP_SQA) begin
      a2_q <= 64'(ua_q) * 64'(ua_q);
    end
    if (cmd_i.op == OP_SQB) begin
      pw_q[cmd_i.bin] <= pwr;
    end
    if (cmd_i.op == OP_AVG1) begin
      acc_q <= 64'(alpha_q) * 64'(pw_q[cmd_i.bin]);
    end
    if (cmd_i.op == OP_AVG2) begin
      pw_q[cmd_i.bin] <= asum[63:16];
    end
    if (cmd_i.op == OP_DEC1) begin
      det1_q <= lhs > rhs;
    end
    if (cmd_i.op == OP_DEC2) begin
      det2_q <= lhs > rhs;
    end
    if (cmd_i.op == OP_OUT) begin
      det_oq   <= det;
      first_oq <= det && first_pend_q;
      cen_oq   <= pw_q[0];
      left_oq  <= pw_q[2];
      right_oq <= pw_q[1];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign detected_o      = det_oq;
  assign first_detect_o  = first_oq;
  assign central_power_o = cen_oq;
  assign left_power_o    = left_oq;
  assign right_power_o   = right_oq;

endmodule

/* design/three_bin_goertzel_tone_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_bin_goertzel_tone_detector_unit: complex three-bin tone detector
// Goertzel recursions on real and imaginary parts for a central bin and its
// two neighbors, block powers, optional smoothing and a ratio decision.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   ---------------------------------
//  sample    in         in_valid_i/in_ready_o   sample_re_i, sample_im_i
//  result    out        out_valid_o/out_ready_i detected_o, first_detect_o, powers
//  config    in         cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// A sample passes through the accept step, six recursion steps through the
// one shared 18x40 coefficient multiplier, and a count update. The sample
// closing a block then runs, per bin, four products, combine and two squares
// (plus the averaging update when enabled), then the decision against each
// neighbor and the output load; this sequence reuses the same multiplier and
// a 32x32 squarer. A result waits in the output register, so the next block
// proceeds; only the next block end stalls on a full output.
// Reset is asynchronous active low; no clearing pass is needed.
//
module three_bin_goertzel_tone_detector_unit #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tbgtd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tbgtd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [tbgtd_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [tbgtd_pkg::SAMPLE_W-1:0] sample_im_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  detected_o,
  output logic                                  first_detect_o,
  output logic [tbgtd_pkg::PWR_W-1:0]           central_power_o,
  output logic [tbgtd_pkg::PWR_W-1:0]           left_power_o,
  output logic [tbgtd_pkg::PWR_W-1:0]           right_power_o
);
  import tbgtd_pkg::*;

  cmd_t cmd;   // controller -> datapath step
  sts_t sts;   // datapath -> controller status

  tbgtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbgtd_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_re_i     (sample_re_i),
    .sample_im_i     (sample_im_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .detected_o      (detected_o),
    .first_detect_o  (first_detect_o),
    .central_power_o (central_power_o),
    .left_power_o    (left_power_o),
    .right_power_o   (right_power_o)
  );

  // a first detection is always a detection
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!first_detect_o || detected_o))
    else $error("first_detect without detected");

  // an enabled request starts the recursion sequence, so intake closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts.mode_en) |=> !in_ready_o)
    else $error("sample taken while recursions pending");

  // a dropped request leaves intake open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !sts.mode_en && !cfg_we_i) |=> in_ready_o)
    else $error("dropped sample stalled intake");

endmodule

/* tb/tb_three_bin_goertzel_tone_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_bin_goertzel_tone_detector_unit: self-checking bench
// Drives complex samples and register writes, predicts every block result
// with a bit-accurate fixed-point Goertzel model, and checks each result in
// order with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_three_bin_goertzel_tone_detector_unit;
  import tbgtd_pkg::*;

  localparam longint ACC_LIM = 64'sd1 << (ACC_W - 1);
  localparam int     DRAIN_CYCLES = 150;  // block end sequence plus output wait

  typedef struct {
    bit              det;
    bit              first;
    logic [PWR_W-1:0] central;
    logic [PWR_W-1:0] left;
    logic [PWR_W-1:0] right;
  } tone_report_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_re_i = '0;
  logic signed [SAMPLE_W-1:0] sample_im_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       detected_o;
  logic                       first_detect_o;
  logic [PWR_W-1:0]           central_power_o;
  logic [PWR_W-1:0]           left_power_o;
  logic [PWR_W-1:0]           right_power_o;

  three_bin_goertzel_tone_detector_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the register file and of the detector state.
  logic [MODE_W-1:0] mdl_mode;
  logic [LEN_W-1:0]  mdl_len;
  logic [CS_W-1:0]   mdl_cs[3];      // 0 central, 1 right, 2 left
  logic [GAIN_W-1:0] mdl_gain;
  logic [GAIN_W-1:0] mdl_alpha;
  logic [PWR_W-1:0]  mdl_floor;
  longint            acc_q1[6];
  longint            acc_q2[6];
  int                blk_fill;
  logic [PWR_W-1:0]  smooth_pwr[3];
  bit                first_armed;

  tone_report_t pending_reports[$];
  int  err_count = 0;
  int  report_count = 0;
  int  detect_count = 0;
  int  samples_sent = 0;
  bit  quiet = 1'b0;        // no idling on either side while set
  int  sink_hold = 0;

  function automatic void clear_acc();
    for (int i = 0; i < 6; i++) begin
      acc_q1[i] = 0;
      acc_q2[i] = 0;
    end
    blk_fill = 0;
  endfunction

  function automatic void clear_smooth();
    for (int b = 0; b < 3; b++) smooth_pwr[b] = '0;
  endfunction

  function automatic void model_reset();
    mdl_mode  = MODE_RST;
    mdl_len   = BLOCK_LEN_RST;
    for (int b = 0; b < 3; b++) mdl_cs[b] = BIN_CS_RST;
    mdl_gain  = THRESH_RST;
    mdl_alpha = ALPHA_RST;
    mdl_floor = '0;
    clear_acc();
    clear_smooth();
    first_armed = 1'b1;
  endfunction

  function automatic longint coef_cos(int b);
    logic signed [COEF_W-1:0] c;
    c = mdl_cs[b][CS_W-1:COEF_W];
    return longint'(c);
  endfunction

  function automatic longint coef_sin(int b);
    logic signed [COEF_W-1:0] s;
    s = mdl_cs[b][COEF_W-1:0];
    return longint'(s);
  endfunction

  // Complex-input power of one bin from its two recursions, floored.
  function automatic logic [PWR_W-1:0] bin_energy(int b);
    longint c, s, rr, ri, ir, ii, a, bb;
    logic [65:0] ua, ub, sum;
    logic [65:0] p;
    c  = coef_cos(b);
    s  = coef_sin(b);
    rr = acc_q1[2*b] - ((c * acc_q2[2*b]) >>> 16);
    ri = (s * acc_q2[2*b]) >>> 16;
    ir = acc_q1[2*b+1] - ((c * acc_q2[2*b+1]) >>> 16);
    ii = (s * acc_q2[2*b+1]) >>> 16;
    a  = rr - ii;
    bb = ir + ri;
    ua = (a < 0) ? 66'(-a) : 66'(a);
    ub = (bb < 0) ? 66'(-bb) : 66'(bb);
    if (ua >= (66'd1 << 32) || ub >= (66'd1 << 32)) begin
      p = 66'(PWR_MAX);
    end else begin
      sum = ua * ua + ub * ub;
      p = sum >> 16;
      if (p > 66'(PWR_MAX)) p = 66'(PWR_MAX);
    end
    if (p <= 66'(mdl_floor)) p = 66'd1;
    return p[PWR_W-1:0];
  endfunction

  function automatic logic [PWR_W-1:0] smooth_step(logic [PWR_W-1:0] avg,
                                                   logic [PWR_W-1:0] p);
    logic [65:0] a, na, acc;
    a   = 66'(mdl_alpha);
    na  = 66'd65536 - a;
    acc = (a * 66'(p) + na * 66'(avg)) >> 16;
    return acc[PWR_W-1:0];
  endfunction

  // Advance the detector by one sample; returns 1 when a block closes.
  function automatic bit tone_predict(logic signed [SAMPLE_W-1:0] re,
                                      logic signed [SAMPLE_W-1:0] im,
                                      output tone_report_t rep);
    longint x[2];
    longint q0, c;
    int len;
    logic [PWR_W-1:0] pw[3];
    logic [65:0] lhs;
    bit det;
    if (!mdl_mode[0]) begin
      clear_acc();
      return 1'b0;
    end
    len = (mdl_len == 0) ? 1 : (mdl_len > 4096) ? 4096 : int'(mdl_len);
    x[0] = longint'(re);
    x[1] = longint'(im);
    for (int b = 0; b < 3; b++) begin
      c = coef_cos(b);
      for (int k = 0; k < 2; k++) begin
        q0 = x[k] + ((c * acc_q1[2*b+k]) >>> 15) - acc_q2[2*b+k];
        if (q0 >= ACC_LIM) q0 = ACC_LIM - 1;
        if (q0 < -ACC_LIM) q0 = -ACC_LIM;
        acc_q2[2*b+k] = acc_q1[2*b+k];
        acc_q1[2*b+k] = q0;
      end
    end
    blk_fill++;
    if (blk_fill < len) return 1'b0;
    for (int b = 0; b < 3; b++) begin
      pw[b] = bin_energy(b);
      if (mdl_mode[1]) begin
        smooth_pwr[b] = smooth_step(smooth_pwr[b], pw[b]);
        pw[b] = smooth_pwr[b];
      end
    end
    clear_acc();
    lhs = 66'(pw[0]) * 66'd256;
    det = (lhs > 66'(pw[2]) * 66'(mdl_gain)) && (lhs > 66'(pw[1]) * 66'(mdl_gain));
    rep.det = det;
    rep.first = 1'b0;
    if (det) begin
      if (first_armed) begin
        rep.first = 1'b1;
        first_armed = 1'b0;
        clear_smooth();
      end
    end else begin
      first_armed = 1'b1;
    end
    rep.central = pw[0];
    rep.left = pw[2];
    rep.right = pw[1];
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: random back-pressure, in-order compare against predictions.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tone_report_t exp_rep;
    if (out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result det=%0b central=%0h", $time, detected_o,
                 central_power_o);
        err_count++;
      end else begin
        exp_rep = pending_reports.pop_front();
        report_count++;
        if (exp_rep.det) detect_count++;
        if (detected_o !== exp_rep.det) begin
          $display("%0t: detected exp %0b got %0b", $time, exp_rep.det, detected_o);
          err_count++;
        end
        if (first_detect_o !== exp_rep.first) begin
          $display("%0t: first_detect exp %0b got %0b", $time, exp_rep.first,
                   first_detect_o);
          err_count++;
        end
        if (central_power_o !== exp_rep.central) begin
          $display("%0t: central_power exp %0h got %0h", $time, exp_rep.central,
                   central_power_o);
          err_count++;
        end
        if (left_power_o !== exp_rep.left) begin
          $display("%0t: left_power exp %0h got %0h", $time, exp_rep.left, left_power_o);
          err_count++;
        end
        if (right_power_o !== exp_rep.right) begin
          $display("%0t: right_power exp %0h got %0h", $time, exp_rep.right,
                   right_power_o);
          err_count++;
        end
      end
      // Draw the stall ahead of the next result.
      sink_hold = quiet ? 0 : $urandom_range(0, 17);
      if (sink_hold != 0) out_ready_i <= 1'b0;
    end else if (!out_ready_i && rst_ni) begin
      if (sink_hold <= 1) out_ready_i <= 1'b1;
      sink_hold--;
    end
  end

  // --------------------------------------------------------------------------
  // Shared driver tasks. Every task returns right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_sample(logic signed [SAMPLE_W-1:0] re,
                             logic signed [SAMPLE_W-1:0] im);
    int gap;
    tone_report_t rep;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    samples_sent++;
    if (tone_predict(re, im, rep)) pending_reports.push_back(rep);
  endtask

  // Hold off requests until every predicted result is out and the block idle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MODE: begin
        mdl_mode = data[MODE_W-1:0];
        clear_smooth();
      end
      REG_BLOCK_LEN: begin
        mdl_len = data[LEN_W-1:0];
        clear_acc();
      end
      REG_CENTRAL_CS: mdl_cs[0] = data[CS_W-1:0];
      REG_RIGHT_CS:   mdl_cs[1] = data[CS_W-1:0];
      REG_LEFT_CS:    mdl_cs[2] = data[CS_W-1:0];
      REG_THRESH:     mdl_gain = data[GAIN_W-1:0];
      REG_ALPHA: begin
        mdl_alpha = data[GAIN_W-1:0];
        clear_smooth();
      end
      REG_FLOOR:      mdl_floor = data[PWR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CS_W-1:0] cs_pair(int c, int s);
    logic [COEF_W-1:0] cb, sb;
    cb = c[COEF_W-1:0];
    sb = s[COEF_W-1:0];
    return {cb, sb};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'sh7fff;
    if (sel == 1) return -16'sh8000;
    if (sel < 4) return SAMPLE_W'($urandom_range(0, 511) - 256);
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic [CS_W-1:0] rand_cs();
    if ($urandom_range(0, 1)) return CS_W'({$urandom, $urandom});
    return cs_pair($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_defaults_short_blocks();
    write_reg(REG_BLOCK_LEN, 4);
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0001);
    send_sample(-16'sh0001, 16'sh0000);
    wait_idle();
    write_reg(REG_CENTRAL_CS, cs_pair(46341, 46341));  // 45 deg
    write_reg(REG_RIGHT_CS, cs_pair(0, 65536));
    write_reg(REG_LEFT_CS, cs_pair(65535, -1));
    for (int i = 0; i < 8; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
  endtask

  // Detection off: requests accepted, dropped, block state cleared.
  task automatic test_detection_off();
    write_reg(REG_MODE, 0);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
    write_reg(REG_MODE, 1);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
  endtask

  // Length zero acts as one; over-range acts as the maximum block, so a
  // partial run of it closes no block.
  task automatic test_block_len_limits();
    write_reg(REG_BLOCK_LEN, 0);
    for (int i = 0; i < 3; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
    write_reg(REG_BLOCK_LEN, 5);
    send_sample(100, -100);
    send_sample(-3000, 3000);
    wait_idle();
    write_reg(REG_BLOCK_LEN, 3);  // restarts the partial block
    for (int i = 0; i < 3; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
    quiet = 1'b1;
    write_reg(REG_BLOCK_LEN, 13'h1fff);
    for (int i = 0; i < 200; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
    quiet = 1'b0;
  endtask

  // Accumulator and power saturation, floor extremes, gain extremes.
  task automatic test_saturation_and_floor();
    write_reg(REG_BLOCK_LEN, 16);
    write_reg(REG_CENTRAL_CS, cs_pair(-131072, -131072));
    write_reg(REG_RIGHT_CS, cs_pair(131071, 131071));
    write_reg(REG_LEFT_CS, cs_pair(-131072, 131071));
    write_reg(REG_THRESH, 0);
    for (int i = 0; i < 16; i++) send_sample(16'sh7fff, -16'sh8000);
    wait_idle();
    write_reg(REG_FLOOR, PWR_MAX);
    write_reg(REG_THRESH, 16'hffff);
    write_reg(REG_BLOCK_LEN, 2);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
    write_reg(REG_FLOOR, 0);
  endtask

  // Averager with zero and full weight.
  task automatic test_averaging();
    write_reg(REG_THRESH, 256);
    write_reg(REG_BLOCK_LEN, 2);
    write_reg(REG_MODE, 3);
    write_reg(REG_ALPHA, 0);
    for (int i = 0; i < 8; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
    write_reg(REG_ALPHA, 16'hffff);
    for (int i = 0; i < 10; i++) send_sample(rand_sample(), rand_sample());
    wait_idle();
  endtask

  // Random phases: new register set, then a burst of mostly short blocks.
  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < 24; ph++) begin
      write_reg(REG_MODE, ($urandom_range(0, 7) == 0) ? 2 * $urandom_range(0, 1)
                                                        : 1 + 2 * $urandom_range(0, 1));
      write_reg(REG_BLOCK_LEN, ($urandom_range(0, 11) == 0) ? $urandom_range(17, 64)
                                                             : $urandom_range(0, 8));
      write_reg(REG_CENTRAL_CS, rand_cs());
      write_reg(REG_RIGHT_CS, rand_cs());
      write_reg(REG_LEFT_CS, rand_cs());
      write_reg(REG_THRESH, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1024));
      write_reg(REG_ALPHA, $urandom);
      write_reg(REG_FLOOR, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} :
                                                          $urandom_range(0, 4096));
      quiet = (ph % 6 == 5);
      n = $urandom_range(15, 30);
      for (int i = 0; i < n; i++) begin
        send_sample(rand_sample(), rand_sample());
        if (ph == 3 && i == n / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_reports.size() != 0);
        end
      end
      wait_idle();
    end
    quiet = 1'b0;
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    out_ready_i <= 1'b1;
    @(posedge clk_i);
    test_defaults_short_blocks();
    test_detection_off();
    test_block_len_limits();
    test_saturation_and_floor();
    test_averaging();
    test_random_phases();
    $display("Sent %0d samples; checked %0d block results, %0d with a detection.",
             samples_sent, report_count, detect_count);
    $display("Covered mode on/off/averaging, block length limits, saturation and floors.");
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d results outstanding", pending_reports.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/tbgtd_pkg.sv
design/tbgtd_ctrl.sv
design/tbgtd_dp.sv
design/three_bin_goertzel_tone_detector_unit.sv
tb/tb_three_bin_goertzel_tone_detector_unit.sv
